### src/jac_pkg.sv
// ----------------------------------------------------------------------------
// jac_pkg
// Shared types and constants for the joystick axis conditioner.
// ----------------------------------------------------------------------------
package jac_pkg;

  localparam int unsigned AXIS_W = 12;
  localparam int unsigned DIV_NW = 24;
  localparam int unsigned DIV_QW = 12;
  localparam int unsigned DIV_CW = 4;

  localparam logic [AXIS_W-1:0] CENTRE = 12'd2048;
  localparam logic [AXIS_W-1:0] FULL   = 12'd4095;
  localparam logic [AXIS_W-1:0] EMA_DIV = 12'd10;

  localparam logic [7:0] Y_BIAS_RST    = 8'd52;
  localparam logic [9:0] DEAD_BAND_RST = 10'd50;

  localparam logic REG_Y_BIAS    = 1'b0;
  localparam logic REG_DEAD_BAND = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_WAIT,
    ST_DONE
  } state_t;

  typedef enum logic [2:0] {
    OP_EMA_X,
    OP_EMA_Y,
    OP_CAL,
    OP_RED,
    OP_BLUE,
    OP_COL,
    OP_ROW
  } op_t;

  typedef struct packed {
    logic              start;
    logic [DIV_NW-1:0] num;
    logic [DIV_QW-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DIV_QW-1:0] quo;
  } div_rsp_t;

  typedef struct packed {
    logic [7:0]        red_level;
    logic [7:0]        blue_level;
    logic [6:0]        square_col;
    logic [5:0]        square_row;
    logic [AXIS_W-1:0] x_value;
    logic [AXIS_W-1:0] y_value;
  } res_t;

endpackage

### src/joystick_axis_conditioner.sv
// ----------------------------------------------------------------------------
// joystick_axis_conditioner
// Smooths a pair of 12-bit joystick samples, applies the centre deadzone and
// Y calibration, and derives LED levels and an 8x8 square position.
//
// A new sample pair is taken only once the previous result is handed over: the
// sequencer runs seven divisions (two smoothing steps, the Y stretch, two
// LED levels, column and row) on one shared radix-2 divider after accepting a
// pair and before handing over the result. in_tready is high
// only while the sequencer is idle. The result sits in an output register, so
// the next pair is taken while a finished result still waits for transfer.
// ----------------------------------------------------------------------------
module joystick_axis_conditioner #(
  parameter int unsigned SCREEN_WIDTH  = 128,
  parameter int unsigned SCREEN_HEIGHT = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [9:0]  cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // raw_x[11:0], raw_y[23:12], leds_enabled[24], zero fill
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata   // red_level[7:0], blue_level[15:8], square_col[22:16],
                                  // square_row[28:23], x_value[40:29], y_value[52:41], zero fill
);
  import jac_pkg::*;

  logic [7:0]  y_bias_r;
  logic [9:0]  dead_band_r;
  logic        out_tvalid_r;
  logic [55:0] out_tdata_r;

  logic     res_valid;
  logic     res_ready;
  res_t     res;
  div_req_t div_req;
  div_rsp_t div_rsp;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      y_bias_r    <= Y_BIAS_RST;
      dead_band_r <= DEAD_BAND_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_Y_BIAS:    y_bias_r    <= cfg_wdata[7:0];
        REG_DEAD_BAND: dead_band_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  jac_ctrl #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_tvalid),
    .in_ready     (in_tready),
    .raw_x        (in_tdata[11:0]),
    .raw_y        (in_tdata[23:12]),
    .leds_enabled (in_tdata[24]),
    .y_bias       (y_bias_r),
    .dead_band    (dead_band_r),
    .res_ready    (res_ready),
    .res_valid    (res_valid),
    .res          (res),
    .div_req      (div_req),
    .div_rsp      (div_rsp)
  );

  jac_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign res_ready = !out_tvalid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (res_ready) begin
      out_tvalid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_tdata_r <= {3'b000, res.y_value, res.x_value, res.square_row,
                      res.square_col, res.blue_level, res.red_level};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule

### src/jac_div.sv
// ----------------------------------------------------------------------------
// jac_div
// Restoring divider, one quotient bit per cycle, 24-bit dividend over a
// 12-bit divisor. The quotient must fit in 12 bits.
// ----------------------------------------------------------------------------
module jac_div (
  input  logic              clk,
  input  logic              rst_n,
  input  jac_pkg::div_req_t req,
  output jac_pkg::div_rsp_t rsp
);
  import jac_pkg::*;

  logic              busy_r;
  logic              done_r;
  logic [DIV_CW-1:0] cnt_r;
  logic [DIV_QW-1:0] rem_r;
  logic [DIV_QW-1:0] num_r;
  logic [DIV_QW-1:0] den_r;

  logic [DIV_QW:0]   trial;
  logic              ge;
  logic [DIV_QW-1:0] rem_nxt;
  logic [DIV_QW-1:0] num_nxt;

  always_comb begin
    trial   = {rem_r, num_r[DIV_QW-1]};
    ge      = trial >= {1'b0, den_r};
    rem_nxt = ge ? DIV_QW'(trial - {1'b0, den_r}) : trial[DIV_QW-1:0];
    num_nxt = {num_r[DIV_QW-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == DIV_CW'(DIV_QW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= req.num[DIV_NW-1:DIV_QW];
      num_r <= req.num[DIV_QW-1:0];
      den_r <= req.den;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      num_r <= num_nxt;
    end
  end

  assign rsp.done = done_r;
  assign rsp.quo  = num_r;

endmodule

### src/jac_ctrl.sv
// ----------------------------------------------------------------------------
// jac_ctrl
// Sequencer and axis state: steps through seven divisions on the shared
// divider and collects one conditioned result per sample pair.
// ----------------------------------------------------------------------------
module jac_ctrl #(
  parameter int unsigned SCREEN_WIDTH  = 128,
  parameter int unsigned SCREEN_HEIGHT = 64
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [jac_pkg::AXIS_W-1:0] raw_x,
  input  logic [jac_pkg::AXIS_W-1:0] raw_y,
  input  logic                      leds_enabled,
  input  logic [7:0]                y_bias,
  input  logic [9:0]                dead_band,
  input  logic                      res_ready,
  output logic                      res_valid,
  output jac_pkg::res_t             res,
  output jac_pkg::div_req_t         div_req,
  input  jac_pkg::div_rsp_t         div_rsp
);
  import jac_pkg::*;

  localparam logic [7:0] COL_SPAN = 8'(SCREEN_WIDTH - 8);
  localparam logic [7:0] ROW_SPAN = 8'(SCREEN_HEIGHT - 8);

  state_t state_r, state_nxt;
  op_t    op_r, op_nxt;

  logic [AXIS_W-1:0] raw_x_r;
  logic [AXIS_W-1:0] raw_y_r;
  logic              leds_r;
  logic [AXIS_W-1:0] sx_r;
  logic [AXIS_W-1:0] sy_r;
  logic [AXIS_W-1:0] y_r;
  logic [7:0]        red_r;
  logic [7:0]        blue_r;
  logic [6:0]        col_r;
  logic [5:0]        row_r;

  logic [AXIS_W-1:0] d12;
  logic [AXIS_W-1:0] off12;
  logic [AXIS_W-1:0] base;
  logic [AXIS_W-1:0] cal_lim;
  logic [AXIS_W-1:0] cal_sub;
  logic [AXIS_W-1:0] cal;
  logic [AXIS_W-1:0] lvl_v;
  logic [AXIS_W:0]   lvl_hi;
  logic [AXIS_W-1:0] lvl_diff;
  logic [AXIS_W-1:0] lvl_den;
  logic [AXIS_W-1:0] emx_old;
  logic [AXIS_W-1:0] emx_raw;
  logic [DIV_NW-1:0] num;
  logic [DIV_QW-1:0] den;

  function automatic logic [AXIS_W-1:0] snap(input logic [AXIS_W-1:0] v,
                                             input logic [9:0] d);
    logic [AXIS_W:0] lo_sum;
    logic [AXIS_W:0] hi_lim;
    begin
      lo_sum = {1'b0, v} + (AXIS_W+1)'(d);
      hi_lim = {1'b0, CENTRE} + (AXIS_W+1)'(d);
      if (lo_sum > {1'b0, CENTRE} && {1'b0, v} < hi_lim) begin
        snap = CENTRE;
      end else begin
        snap = v;
      end
    end
  endfunction

  always_comb begin
    d12     = AXIS_W'(dead_band);
    off12   = AXIS_W'(y_bias);
    base    = CENTRE - d12;
    cal_lim = FULL - off12;
    cal_sub = (sy_r >= off12) ? sy_r - off12 : '0;
    cal     = (cal_sub > cal_lim) ? cal_lim : cal_sub;

    lvl_v    = (op_r == OP_RED) ? sx_r : y_r;
    lvl_hi   = {1'b0, CENTRE} + (AXIS_W+1)'(dead_band);
    lvl_diff = '0;
    lvl_den  = base;
    if (lvl_v < CENTRE) begin
      if (lvl_v <= base) begin
        lvl_diff = base - lvl_v;
      end
    end else if ({1'b0, lvl_v} > lvl_hi) begin
      lvl_diff = AXIS_W'({1'b0, lvl_v} - lvl_hi);
      lvl_den  = 12'd2047 - d12;
    end

    emx_old = (op_r == OP_EMA_X) ? sx_r : sy_r;
    emx_raw = (op_r == OP_EMA_X) ? raw_x_r : raw_y_r;

    case (op_r)
      OP_EMA_X, OP_EMA_Y: begin
        num = DIV_NW'(emx_raw) + DIV_NW'({emx_old, 3'b000}) + DIV_NW'(emx_old);
        den = EMA_DIV;
      end
      OP_CAL: begin
        num = {cal, {AXIS_W{1'b0}}} - DIV_NW'(cal);
        den = cal_lim;
      end
      OP_RED, OP_BLUE: begin
        num = DIV_NW'({lvl_diff, 8'h00}) - DIV_NW'(lvl_diff);
        den = lvl_den;
      end
      OP_COL: begin
        num = DIV_NW'(20'(sx_r) * 20'(COL_SPAN));
        den = FULL;
      end
      OP_ROW: begin
        num = DIV_NW'(20'(FULL - y_r) * 20'(ROW_SPAN));
        den = FULL;
      end
      default: begin
        num = '0;
        den = FULL;
      end
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    in_ready      = 1'b0;
    res_valid     = 1'b0;
    div_req.start = 1'b0;
    div_req.num   = num;
    div_req.den   = den;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          op_nxt    = OP_EMA_X;
          state_nxt = ST_LOAD;
        end
      end
      ST_LOAD: begin
        div_req.start = 1'b1;
        state_nxt     = ST_WAIT;
      end
      ST_WAIT: begin
        if (div_rsp.done) begin
          state_nxt = ST_LOAD;
          case (op_r)
            OP_EMA_X: op_nxt = OP_EMA_Y;
            OP_EMA_Y: op_nxt = OP_CAL;
            OP_CAL:   op_nxt = OP_RED;
            OP_RED:   op_nxt = OP_BLUE;
            OP_BLUE:  op_nxt = OP_COL;
            OP_COL:   op_nxt = OP_ROW;
            default:  state_nxt = ST_DONE;
          endcase
        end
      end
      ST_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      op_r    <= OP_EMA_X;
      sx_r    <= CENTRE;
      sy_r    <= CENTRE;
    end else begin
      state_r <= state_nxt;
      op_r    <= op_nxt;
      if (state_r == ST_WAIT && div_rsp.done) begin
        case (op_r)
          OP_EMA_X: sx_r <= snap(div_rsp.quo, dead_band);
          OP_EMA_Y: sy_r <= div_rsp.quo;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_valid) begin
      raw_x_r <= raw_x;
      raw_y_r <= raw_y;
      leds_r  <= leds_enabled;
    end
    if (state_r == ST_WAIT && div_rsp.done) begin
      case (op_r)
        OP_CAL:  y_r    <= snap(div_rsp.quo, dead_band);
        OP_RED:  red_r  <= leds_r ? div_rsp.quo[7:0] : 8'h00;
        OP_BLUE: blue_r <= leds_r ? div_rsp.quo[7:0] : 8'h00;
        OP_COL:  col_r  <= div_rsp.quo[6:0];
        OP_ROW:  row_r  <= div_rsp.quo[5:0];
        default: ;
      endcase
    end
  end

  assign res.red_level  = red_r;
  assign res.blue_level = blue_r;
  assign res.square_col = col_r;
  assign res.square_row = row_r;
  assign res.x_value    = sx_r;
  assign res.y_value    = y_r;

endmodule

### bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the joystick axis conditioner. A directed table of
// sample pairs and register writes is followed by random phases under
// different calibration settings. Inputs are mostly held targets, so the
// smoothed values settle on the extremes, the centre and the deadzone edges.
// Each accepted pair is run through a local model of the smoothing, deadzone,
// calibration and LED/square mapping. Each result transfer is compared
// against the oldest expected result. Both sides of the stream idle at random.
// ----------------------------------------------------------------------------
module testbench;
  import jac_pkg::*;

  localparam int unsigned SCR_W        = 128;
  localparam int unsigned SCR_H        = 64;
  localparam int unsigned HOLD_CYCLES  = 1500;
  localparam int unsigned STALL_LIMIT  = 20000;
  localparam int unsigned SETTLE_CYCLES = 200;
  localparam int unsigned PHASES       = 8;
  localparam int unsigned PHASE_ITEMS  = 92;

  typedef struct packed {
    logic [11:0] raw_x;
    logic [11:0] raw_y;
    logic        leds;
  } stick_t;

  typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_t;

  typedef struct {
    row_kind_t  kind;
    stick_t     smp;
    logic       idx;
    logic [9:0] val;
    bit         typed;
    res_t       want;
  } row_t;

  typedef enum logic [1:0] {RX_FREE, RX_LIGHT, RX_HEAVY, RX_PULSE} rx_mode_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic [9:0]  cfg_wdata = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [55:0] out_tdata;

  // local copy of block state and registers
  int unsigned avg_x, avg_y, y_trim, band;

  res_t        pending_results[$];
  row_t        directed_rows[$];
  int unsigned mismatches = 0;
  int unsigned burst_left = 0;
  int unsigned hold_asks = 0;
  int unsigned stall_cycles = 0;

  joystick_axis_conditioner #(
    .SCREEN_WIDTH (SCR_W),
    .SCREEN_HEIGHT(SCR_H)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic int unsigned dz_snap(int unsigned v, int unsigned d);
    if (v + d > 2048 && v < 2048 + d) return 2048;
    return v;
  endfunction

  function automatic int unsigned led_level(int unsigned v, int unsigned d);
    int unsigned base;
    base = 2048 - d;
    if (v < 2048) begin
      if (v > base) return 0;
      return ((base - v) * 255) / base;
    end
    if (v > 2048 + d) return ((v - 2048 - d) * 255) / (2047 - d);
    return 0;
  endfunction

  function automatic res_t condition_sample(stick_t s);
    res_t        r;
    int unsigned x, y, cal;
    avg_x = ((s.raw_x + 9 * avg_x) / 10) & 12'hFFF;
    avg_y = ((s.raw_y + 9 * avg_y) / 10) & 12'hFFF;
    x = dz_snap(avg_x, band);
    avg_x = x;
    cal = (avg_y >= y_trim) ? avg_y - y_trim : 0;
    if (cal > 4095 - y_trim) cal = 4095 - y_trim;
    y = dz_snap((cal * 4095) / (4095 - y_trim), band);
    r.red_level  = s.leds ? 8'(led_level(x, band)) : 8'd0;
    r.blue_level = s.leds ? 8'(led_level(y, band)) : 8'd0;
    r.square_col = 7'((x * (SCR_W - 8)) / 4095);
    r.square_row = 6'(((4095 - y) * (SCR_H - 8)) / 4095);
    r.x_value    = 12'(x);
    r.y_value    = 12'(y);
    return r;
  endfunction

  function automatic logic [11:0] pick_axis();
    int c, j;
    c = $urandom_range(0, 6);
    j = $urandom_range(0, 40);
    case (c)
      0: return 12'd0;
      1: return 12'd4095;
      2: return 12'd2048;
      3: return 12'(2048 + int'(band) + j - 20);
      4: return 12'(2048 - int'(band) + j - 20);
      default: return 12'($urandom_range(0, 4095));
    endcase
  endfunction

  function automatic row_t sample_row(logic [11:0] x, logic [11:0] y, logic l);
    row_t r;
    r.kind  = ROW_SAMPLE;
    r.smp   = '{raw_x: x, raw_y: y, leds: l};
    r.idx   = REG_Y_BIAS;
    r.val   = '0;
    r.typed = 1'b0;
    r.want  = '0;
    return r;
  endfunction

  function automatic row_t write_row(logic idx, logic [9:0] val);
    row_t r;
    r = sample_row(12'd0, 12'd0, 1'b0);
    r.kind = ROW_WRITE;
    r.idx  = idx;
    r.val  = val;
    return r;
  endfunction

  task automatic log_failure(string what, res_t want, res_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%s: want red=%0d blue=%0d col=%0d row=%0d x=%0d y=%0d", what,
               want.red_level, want.blue_level, want.square_col, want.square_row,
               want.x_value, want.y_value);
      $display("%s:  got red=%0d blue=%0d col=%0d row=%0d x=%0d y=%0d", what,
               got.red_level, got.blue_level, got.square_col, got.square_row,
               got.x_value, got.y_value);
    end
  endtask

  task automatic send_sample(stick_t s, bit typed, res_t want);
    res_t pred;
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
      if (gap > 0) begin
        @(negedge clk);
        in_tvalid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= {7'd0, s.leds, s.raw_y, s.raw_x};
    do @(posedge clk); while (!in_tready);
    pred = condition_sample(s);
    pending_results.push_back(typed ? want : pred);
  endtask

  // drop valid and hold until every expected transfer is in
  task automatic settle_idle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [9:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_Y_BIAS) y_trim = val[7:0];
    else band = val;
  endtask

  task automatic run_phase(int unsigned count);
    stick_t      s;
    logic [11:0] tx, ty;
    int unsigned run, k, sent;
    sent = 0;
    while (sent < count) begin
      tx  = pick_axis();
      ty  = pick_axis();
      run = ($urandom_range(0, 4) == 0) ? 1 : $urandom_range(3, 40);
      for (k = 0; k < run && sent < count; k++) begin
        s.raw_x = ($urandom_range(0, 3) == 0) ? tx ^ 12'($urandom_range(0, 7)) : tx;
        s.raw_y = ($urandom_range(0, 3) == 0) ? ty ^ 12'($urandom_range(0, 7)) : ty;
        s.leds  = ($urandom_range(0, 4) != 0);
        send_sample(s, 1'b0, '0);
        sent++;
      end
    end
  endtask

  // receiver: long hold on request, otherwise a changing stall pattern
  always @(negedge clk) begin : rx_side
    static int unsigned hold_seen = 0;
    static int unsigned hold_left = 0;
    static int unsigned mode_left = 0;
    static int unsigned tick = 0;
    static rx_mode_t    mode = RX_FREE;
    tick++;
    if (hold_seen != hold_asks) begin
      hold_seen = hold_asks;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        mode = rx_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(50, 400);
      end
      mode_left--;
      case (mode)
        RX_FREE:  out_tready <= 1'b1;
        RX_LIGHT: out_tready <= ($urandom_range(0, 3) != 0);
        RX_HEAVY: out_tready <= ($urandom_range(0, 3) == 0);
        default:  out_tready <= (tick % 7 < 3);
      endcase
    end
  end

  always @(posedge clk) begin : result_check
    res_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got.red_level  = out_tdata[7:0];
      got.blue_level = out_tdata[15:8];
      got.square_col = out_tdata[22:16];
      got.square_row = out_tdata[28:23];
      got.x_value    = out_tdata[40:29];
      got.y_value    = out_tdata[52:41];
      if (pending_results.size() == 0) begin
        log_failure("unexpected transfer", '0, got);
      end else begin
        want = pending_results.pop_front();
        if (got !== want) log_failure("mismatch", want, got);
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin : stimulus
    row_t        r;
    int unsigned p;
    static int unsigned trim_set[5] = '{0, 255, 52, 255, 0};
    static int unsigned band_set[5] = '{0, 1023, 50, 0, 1023};

    avg_x  = 2048;
    avg_y  = 2048;
    y_trim = Y_BIAS_RST;
    band   = DEAD_BAND_RST;

    // reset values, extremes, deadzone edges, LEDs off
    r = sample_row(12'd2048, 12'd2048, 1'b1);
    r.typed = 1'b1;
    r.want  = '{red_level: 8'd0, blue_level: 8'd0, square_col: 7'd60,
               square_row: 6'd27, x_value: 12'd2048, y_value: 12'd2048};
    directed_rows.push_back(r);
    r.smp.leds = 1'b0;
    directed_rows.push_back(r);
    directed_rows.push_back(sample_row(12'd4095, 12'd4095, 1'b1));
    directed_rows.push_back(sample_row(12'd4095, 12'd4095, 1'b1));
    directed_rows.push_back(sample_row(12'd0, 12'd0, 1'b1));
    directed_rows.push_back(sample_row(12'd0, 12'd4095, 1'b0));
    directed_rows.push_back(sample_row(12'd4095, 12'd0, 1'b1));
    directed_rows.push_back(sample_row(12'd2100, 12'd1990, 1'b1));
    // no deadzone
    directed_rows.push_back(write_row(REG_DEAD_BAND, 10'd0));
    directed_rows.push_back(sample_row(12'd2048, 12'd2048, 1'b1));
    directed_rows.push_back(sample_row(12'd2049, 12'd2047, 1'b1));
    directed_rows.push_back(sample_row(12'd0, 12'd0, 1'b1));
    // widest band above its range, largest offset
    directed_rows.push_back(write_row(REG_Y_BIAS, 10'd255));
    directed_rows.push_back(write_row(REG_DEAD_BAND, 10'd1023));
    directed_rows.push_back(sample_row(12'd4095, 12'd4095, 1'b1));
    directed_rows.push_back(sample_row(12'd4095, 12'd4095, 1'b1));
    directed_rows.push_back(sample_row(12'd2048, 12'd2048, 1'b1));
    directed_rows.push_back(sample_row(12'd3000, 12'd1000, 1'b1));
    directed_rows.push_back(sample_row(12'd0, 12'd0, 1'b0));
    // no offset, band at top of range
    directed_rows.push_back(write_row(REG_Y_BIAS, 10'd0));
    directed_rows.push_back(write_row(REG_DEAD_BAND, 10'd1000));
    directed_rows.push_back(sample_row(12'd4095, 12'd4095, 1'b1));
    directed_rows.push_back(sample_row(12'd1500, 12'd2600, 1'b1));
    directed_rows.push_back(sample_row(12'd0, 12'd0, 1'b1));

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_WRITE) begin
        settle_idle();
        write_reg(directed_rows[i].idx, directed_rows[i].val);
      end else begin
        send_sample(directed_rows[i].smp, directed_rows[i].typed, directed_rows[i].want);
      end
    end

    for (p = 0; p < PHASES; p++) begin
      settle_idle();
      if (p < 5) begin
        write_reg(REG_Y_BIAS, 10'(trim_set[p]));
        write_reg(REG_DEAD_BAND, 10'(band_set[p]));
      end else begin
        write_reg(REG_Y_BIAS, 10'($urandom_range(0, 255)));
        write_reg(REG_DEAD_BAND, 10'($urandom_range(0, 1023)));
      end
      // hold the result side while samples keep coming
      if (p == 2) hold_asks++;
      run_phase(PHASE_ITEMS);
    end

    settle_idle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
